// ===== design/slfd_pkg.sv =====
package slfd_pkg;

    // Frame delimiters and the reset value of the acknowledge code register.
    localparam logic [7:0] SYNC_FIRST     = 8'hF5;
    localparam logic [7:0] SYNC_SECOND    = 8'hAF;
    localparam logic [7:0] ACK_CODE_RESET = 8'hF0;

    // Verdict codes carried on the last result of a frame.
    localparam logic [1:0] VERDICT_OTHER = 2'd0;
    localparam logic [1:0] VERDICT_ACK   = 2'd1;
    localparam logic [1:0] VERDICT_NACK  = 2'd2;

    // One result item.
    typedef struct packed {
        logic [7:0] code;
        logic [7:0] data_byte;
        logic       has_data;
        logic [5:0] byte_index;
        logic       frame_end;
        logic [1:0] verdict;
    } t_result;

endpackage

// ===== design/slfd_parser.sv =====
module slfd_parser #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [7:0]       i_rx_byte,
    output logic             o_in_stall,
    input  logic             i_advance,
    input  logic [7:0]       i_ack_code,
    output logic             o_fire,
    output logic             o_res_valid,
    output slfd_pkg::t_result o_res
);
    import slfd_pkg::*;

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    localparam logic [2:0] PH_SYNC1  = 3'd0;
    localparam logic [2:0] PH_SYNC2  = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_CODE   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic [2:0]       r_phase,   n_phase;
    logic [LEN_W-1:0] r_length,  n_length;
    logic [7:0]       r_code,    n_code;
    logic [LEN_W-1:0] r_seen,    n_seen;
    logic [7:0]       r_first,   n_first;
    logic             accept;
    logic             fire;
    logic [LEN_W-1:0] seen_inc;
    logic [7:0]       first_now;
    logic             ack_match;

    // Input register: holds one byte until the result side can take it.
    assign fire       = r_in_valid & i_advance;
    assign o_in_stall = r_in_valid & ~i_advance;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_fire     = fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // The first payload byte seen by this step, used for the verdict.
    assign seen_inc  = r_seen + LEN_W'(1);
    assign first_now = (r_seen == '0) ? r_in_byte : r_first;
    assign ack_match = (r_code == i_ack_code);

    // Phase update and result formation for the byte in the input register.
    always_comb begin
        n_phase     = r_phase;
        n_length    = r_length;
        n_code      = r_code;
        n_seen      = r_seen;
        n_first     = r_first;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (r_phase)
            PH_SYNC1: begin
                if (r_in_byte == SYNC_FIRST) begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                n_phase = (r_in_byte == SYNC_SECOND) ? PH_LENGTH : PH_SYNC1;
            end
            PH_LENGTH: begin
                if ({1'b0, r_in_byte} <= 9'(MAX_PAYLOAD)) begin
                    n_length = LEN_W'(r_in_byte);
                    n_phase  = PH_CODE;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_CODE: begin
                n_code = r_in_byte;
                n_seen = '0;
                if (r_length != '0) begin
                    n_phase = PH_DATA;
                end else begin
                    // Empty frame: one result at the command byte.
                    n_phase         = PH_SYNC1;
                    o_res_valid     = 1'b1;
                    o_res.code      = r_in_byte;
                    o_res.frame_end = 1'b1;
                    if (r_in_byte != i_ack_code) begin
                        o_res.verdict = VERDICT_OTHER;
                    end else begin
                        o_res.verdict = (r_first == 8'd0) ? VERDICT_ACK : VERDICT_NACK;
                    end
                end
            end
            PH_DATA: begin
                n_first          = first_now;
                n_seen           = seen_inc;
                o_res_valid      = 1'b1;
                o_res.code       = r_code;
                o_res.data_byte  = r_in_byte;
                o_res.has_data   = 1'b1;
                o_res.byte_index = 6'(r_seen);
                if (seen_inc >= r_length) begin
                    n_phase         = PH_SYNC1;
                    o_res.frame_end = 1'b1;
                    if (!ack_match) begin
                        o_res.verdict = VERDICT_OTHER;
                    end else begin
                        o_res.verdict = (first_now == 8'd0) ? VERDICT_ACK : VERDICT_NACK;
                    end
                end
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
    end

    // Frame state, advanced only when the byte is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC1;
            r_length <= '0;
            r_code   <= '0;
            r_seen   <= '0;
            r_first  <= '0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_code   <= n_code;
            r_seen   <= n_seen;
            r_first  <= n_first;
        end
    end

    // A result that does not end a frame never carries a verdict.
    a_verdict_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.frame_end |-> o_res.verdict == VERDICT_OTHER)
        else $error("verdict set on a result that does not end a frame");

    // An empty result is always the single, final result of its frame.
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.has_data |-> o_res.frame_end && o_res.data_byte == 8'd0)
        else $error("empty result not marked as frame end");

    // Once a frame's last result is consumed, the parser hunts again.
    a_end_rehunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && o_res_valid && o_res.frame_end |=> r_phase == PH_SYNC1)
        else $error("parser did not return to the hunt after frame end");

endmodule

// ===== design/slfd_out_reg.sv =====
module slfd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_res_valid,
    input  slfd_pkg::t_result i_res,
    output logic              o_advance,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output slfd_pkg::t_result o_res
);
    import slfd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register takes a new item whenever it is empty or being emptied.
    assign o_advance = ~r_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load & i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

// ===== design/sync_length_frame_deframer.sv =====
// Channel  | Direction | Handshake                   | Payload
// input    | in        | i_in_valid / o_in_stall     | i_rx_byte
// result   | out       | o_out_valid / i_out_stall   | o_code .. o_verdict
// config   | in        | i_cfg_valid / o_cfg_ready   | i_cfg_data (ack code)
//
// One byte is accepted every cycle while o_in_stall is low; a result passes
// through the input register and then the result register before it leaves.
// The phase update is one short step per byte, which sets the one-byte rate.
// Reset is synchronous and active low; it clears the frame state and sets the
// acknowledge code to 0xF0. A stall on the result side holds a full result
// register and raises o_in_stall while the input register holds a byte.
module sync_length_frame_deframer #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_code,
    output logic [7:0] o_data_byte,
    output logic       o_has_data,
    output logic [5:0] o_byte_index,
    output logic       o_frame_end,
    output logic [1:0] o_verdict,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import slfd_pkg::*;

    logic       r_ack_code;
    logic [7:0] r_ack;
    logic       advance;
    logic       fire;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // Acknowledge code register, always writable.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack <= ACK_CODE_RESET;
        end else if (i_cfg_valid) begin
            r_ack <= i_cfg_data;
        end
    end

    // Marks that the register has been written since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_code <= 1'b0;
        end else if (i_cfg_valid) begin
            r_ack_code <= 1'b1;
        end
    end

    slfd_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_rx_byte   (i_rx_byte),
        .o_in_stall  (o_in_stall),
        .i_advance   (advance),
        .i_ack_code  (r_ack),
        .o_fire      (fire),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    slfd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (out_res)
    );

    // Result fields, each on a port of its own.
    assign o_code       = out_res.code;
    assign o_data_byte  = out_res.data_byte;
    assign o_has_data   = out_res.has_data;
    assign o_byte_index = out_res.byte_index;
    assign o_frame_end  = out_res.frame_end;
    assign o_verdict    = out_res.verdict;

    // The acknowledge code only leaves its reset value through a write.
    a_ack_reset_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ack_code |-> r_ack == ACK_CODE_RESET)
        else $error("acknowledge code changed without a write");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import slfd_pkg::*;

    localparam int MAX_PAYLOAD = 64;
    localparam int PHASE_BYTES = 260;
    localparam int SETTLE_CYCLES = 8;

    // Parser phases, in the order a frame walks through them.
    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_LENGTH,
        TAKE_CODE,
        TAKE_DATA
    } t_rx_phase;

    // Frame parser prediction and the results it still expects to see.
    class deframe_scoreboard;
        logic [7:0] ack_code;
        t_rx_phase  rx_phase;
        int         frame_len;
        logic [7:0] frame_code;
        int         payload_seen;
        logic [7:0] first_payload;
        t_result    pending_results[$];
        int         mismatches;

        function new();
            ack_code      = ACK_CODE_RESET;
            rx_phase      = HUNT_FIRST;
            frame_len     = 0;
            frame_code    = 8'h00;
            payload_seen  = 0;
            first_payload = 8'h00;
            mismatches    = 0;
        endfunction

        // The verdict looks at the frame's first payload byte, or for an empty frame at the one kept from earlier.
        function logic [1:0] frame_verdict();
            if (frame_code != ack_code) begin
                return VERDICT_OTHER;
            end
            return (first_payload == 8'h00) ? VERDICT_ACK : VERDICT_NACK;
        endfunction

        // Advance the parser by one accepted byte and queue any result it gives.
        function void note_rx_byte(logic [7:0] rx);
            t_result r;
            r = '0;
            case (rx_phase)
                HUNT_FIRST: begin
                    if (rx == SYNC_FIRST) begin
                        rx_phase = HUNT_SECOND;
                    end
                end
                HUNT_SECOND: begin
                    rx_phase = (rx == SYNC_SECOND) ? TAKE_LENGTH : HUNT_FIRST;
                end
                TAKE_LENGTH: begin
                    if (int'(rx) <= MAX_PAYLOAD) begin
                        frame_len = int'(rx);
                        rx_phase  = TAKE_CODE;
                    end else begin
                        rx_phase = HUNT_FIRST;
                    end
                end
                TAKE_CODE: begin
                    frame_code   = rx;
                    payload_seen = 0;
                    if (frame_len > 0) begin
                        rx_phase = TAKE_DATA;
                    end else begin
                        rx_phase    = HUNT_FIRST;
                        r.code      = frame_code;
                        r.frame_end = 1'b1;
                        r.verdict   = frame_verdict();
                        pending_results.push_back(r);
                    end
                end
                TAKE_DATA: begin
                    if (payload_seen == 0) begin
                        first_payload = rx;
                    end
                    r.code       = frame_code;
                    r.data_byte  = rx;
                    r.has_data   = 1'b1;
                    r.byte_index = payload_seen[5:0];
                    payload_seen++;
                    if (payload_seen >= frame_len) begin
                        rx_phase    = HUNT_FIRST;
                        r.frame_end = 1'b1;
                        r.verdict   = frame_verdict();
                    end
                    pending_results.push_back(r);
                end
                default: begin
                    rx_phase = HUNT_FIRST;
                end
            endcase
        endfunction

        // Compare one accepted result with the oldest one still expected.
        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result code=%02h data=%02h has=%0d idx=%0d end=%0d verdict=%0d",
                         $time, got.code, got.data_byte, got.has_data, got.byte_index,
                         got.frame_end, got.verdict);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                mismatches++;
                $display("%0t: result mismatch, expected code=%02h data=%02h has=%0d idx=%0d end=%0d verdict=%0d",
                         $time, want.code, want.data_byte, want.has_data, want.byte_index,
                         want.frame_end, want.verdict);
                $display("%0t:                  actual code=%02h data=%02h has=%0d idx=%0d end=%0d verdict=%0d",
                         $time, got.code, got.data_byte, got.has_data, got.byte_index,
                         got.frame_end, got.verdict);
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_code;
    logic [7:0] o_data_byte;
    logic       o_has_data;
    logic [5:0] o_byte_index;
    logic       o_frame_end;
    logic [1:0] o_verdict;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    deframe_scoreboard sb;
    int bytes_sent;
    int in_run_left;
    bit in_calm;
    int out_run_left;
    bit out_calm;

    sync_length_frame_deframer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_code       (o_code),
        .o_data_byte  (o_data_byte),
        .o_has_data   (o_has_data),
        .o_byte_index (o_byte_index),
        .o_frame_end  (o_frame_end),
        .o_verdict    (o_verdict),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Free-running clock.
    always #1 i_clk = ~i_clk;

    // Idle times come in runs: some runs have no idling at all.
    function automatic int draw_wait(inout int run_left, inout bit calm);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 40);
            calm     = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // Offer one byte and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = draw_wait(in_run_left, in_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= value;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    // Wait until every expected result has left, then let the pipeline settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the acknowledge code; only called while the block is idle.
    task automatic write_ack_code(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.ack_code = value;
    endtask

    // Mostly well-formed frames with random content, with noise and broken frames mixed in.
    task automatic run_random_frames(input int n_bytes);
        logic [7:0] frame_bytes[$];
        int kind;
        int len;
        int keep;
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            frame_bytes.delete();
            kind = $urandom_range(0, 9);
            if (kind <= 6 || kind == 9) begin
                case ($urandom_range(0, 15))
                    0: len = MAX_PAYLOAD;
                    1: len = 0;
                    2: len = $urandom_range(0, MAX_PAYLOAD);
                    default: len = $urandom_range(1, 6);
                endcase
                frame_bytes.push_back(SYNC_FIRST);
                frame_bytes.push_back(SYNC_SECOND);
                frame_bytes.push_back(8'(len));
                frame_bytes.push_back($urandom_range(0, 1) ? sb.ack_code : 8'($urandom));
                for (int i = 0; i < len; i++) begin
                    if (i == 0 && $urandom_range(0, 1)) begin
                        frame_bytes.push_back(8'h00);
                    end else begin
                        frame_bytes.push_back(8'($urandom));
                    end
                end
                if (kind == 9) begin
                    // A frame cut short, or one with an oversized length.
                    if ($urandom_range(0, 1)) begin
                        frame_bytes[2] = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
                        keep = 3;
                    end else begin
                        keep = $urandom_range(1, frame_bytes.size());
                    end
                    while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
                end
            end else if (kind == 7) begin
                repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
            end else begin
                frame_bytes.push_back(SYNC_FIRST);
                frame_bytes.push_back(8'($urandom));
            end
            foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
        end
    endtask

    // Note every byte the block accepts.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.note_rx_byte(i_rx_byte);
        end
    end

    // Check every result the block hands over.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result({o_code, o_data_byte, o_has_data, o_byte_index,
                             o_frame_end, o_verdict});
        end
    end

    // Result side: stall for a random number of cycles before taking each item.
    initial begin
        int n;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = draw_wait(out_run_left, out_calm);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Main sequence: reset, directed frames, then random frames under several codes.
    initial begin
        logic [7:0] directed_bytes[$];
        logic [7:0] codes[$];
        sb           = new();
        bytes_sent   = 0;
        in_run_left  = 0;
        out_run_left = 0;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_rx_byte    = 8'h00;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty acknowledge frame judged by the reset first byte, a two-byte
        // frame that turns the verdict to nack, a wrong second sync byte, an
        // oversized length, an empty frame judged by the byte kept from
        // before, and a frame with some other code.
        directed_bytes = '{
            SYNC_FIRST, SYNC_SECOND, 8'h00, ACK_CODE_RESET,
            SYNC_FIRST, SYNC_SECOND, 8'h02, ACK_CODE_RESET, 8'hFF, 8'h00,
            SYNC_FIRST, SYNC_FIRST, SYNC_SECOND,
            SYNC_FIRST, SYNC_SECOND, 8'(MAX_PAYLOAD + 1),
            SYNC_FIRST, SYNC_SECOND, 8'h00, ACK_CODE_RESET,
            SYNC_FIRST, SYNC_SECOND, 8'h01, 8'h00, 8'h00
        };
        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        run_random_frames(PHASE_BYTES);

        codes = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
        foreach (codes[i]) begin
            wait_drained();
            write_ack_code(codes[i]);
            run_random_frames(PHASE_BYTES);
        end

        wait_drained();
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/slfd_pkg.sv
design/slfd_parser.sv
design/slfd_out_reg.sv
design/sync_length_frame_deframer.sv
tb/sv/tb.sv
